@@ hw/rtl/nvme_io_queue_pair_host_defines.svh @@
// Assertion macros shared by the queue pair checker.
`ifndef NVME_IO_QUEUE_PAIR_HOST_DEFINES_SVH
`define NVME_IO_QUEUE_PAIR_HOST_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define NVQP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define NVQP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/nvqp_pkg.sv @@
// Types and constants of the NVMe I/O queue pair host block.
package nvqp_pkg;

  localparam int QUEUE_DEPTH         = 64;
  localparam int MAX_BLOCKS_PER_CMD  = 8;
  localparam int MAX_REQUEST_SECTORS = 512;
  localparam int MAX_RESULTS         = 64;

  localparam int OP_W     = 2;
  localparam int LBA_W    = 64;
  localparam int COUNT_W  = 10;
  localparam int STATUS_W = 16;
  localparam int KIND_W   = 2;
  localparam int OPC_W    = 2;
  localparam int CID_W    = 16;
  localparam int NS_W     = 32;
  localparam int BM1_W    = 3;
  localparam int SLOT_W   = 6;
  localparam int DBOFF_W  = 19;
  localparam int STRIDE_W = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int PTR_W    = $clog2(QUEUE_DEPTH);

  // Largest sector count accepted: bounded by the request limit and by the
  // number of commands one request may produce.
  localparam int REQ_LIMIT_I = (MAX_REQUEST_SECTORS < MAX_RESULTS * MAX_BLOCKS_PER_CMD) ?
                               MAX_REQUEST_SECTORS : MAX_RESULTS * MAX_BLOCKS_PER_CMD;
  localparam logic [COUNT_W-1:0] REQ_LIMIT  = COUNT_W'(REQ_LIMIT_I);
  localparam logic [COUNT_W-1:0] CHUNK_MAX  = COUNT_W'(MAX_BLOCKS_PER_CMD);

  localparam logic [DBOFF_W-1:0] DOORBELL_BASE = 19'h01000;

  // Input operations.
  localparam logic [OP_W-1:0] OP_READ       = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE      = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH      = 2'd2;
  localparam logic [OP_W-1:0] OP_COMPLETION = 2'd3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_SUBMIT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CONSUMED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NOT_READY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REJECTED  = 2'd3;

  // Command opcodes.
  localparam logic [OPC_W-1:0] OPC_FLUSH = 2'h0;
  localparam logic [OPC_W-1:0] OPC_WRITE = 2'h1;
  localparam logic [OPC_W-1:0] OPC_READ  = 2'h2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DOORBELL_STRIDE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NAMESPACE_ID    = 1'd1;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [LBA_W-1:0]    lba;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] cpl_status;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [OPC_W-1:0]   opcode;
    logic [CID_W-1:0]   command_id;
    logic [NS_W-1:0]    namespace;
    logic [LBA_W-1:0]   start_block;
    logic [BM1_W-1:0]   blocks_minus_one;
    logic [SLOT_W-1:0]  slot;
    logic [DBOFF_W-1:0] doorbell_offset;
    logic [SLOT_W-1:0]  doorbell_value;
    logic               error;
    logic               last;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic final_beat;
  } dp_sts_t;

endpackage

@@ hw/rtl/nvqp_if.sv @@
// Valid/ready channel interfaces for request and result beats.
interface nvqp_in_if import nvqp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface nvqp_out_if import nvqp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/nvqp_ctrl.sv @@
// Controller state machine of the queue pair host.
module nvqp_ctrl import nvqp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WORK = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd.load = in_valid && (state_r == ST_IDLE);
    cmd.emit = (state_r == ST_WORK) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ST_WORK;
        end
      end
      ST_WORK: begin
        if (cmd.emit && sts.final_beat) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/nvqp_dp.sv @@
// Datapath of the queue pair host: queue pointers, request split, result register.
module nvqp_dp import nvqp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_item_t              in_data,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  output out_item_t             out_data
);

  // Configuration and queue state.
  logic [STRIDE_W-1:0] stride_r;
  logic [NS_W-1:0]     ns_r;
  logic [PTR_W-1:0]    sq_tail_r, sq_tail_nxt;
  logic [PTR_W-1:0]    cq_head_r, cq_head_nxt;
  logic                phase_r, phase_nxt;
  logic [CID_W-1:0]    cid_r, cid_nxt;

  // Working copy of the item in progress.
  logic [OP_W-1:0]     op_r;
  logic [LBA_W-1:0]    lba_r, lba_nxt;
  logic [COUNT_W-1:0]  left_r, left_nxt;
  logic [STATUS_W-1:0] status_r;

  out_item_t out_r, res;

  logic [PTR_W-1:0]    tail_inc, head_inc;
  logic                head_wrap;
  logic [NS_W-1:0]     eff_ns;
  logic [DBOFF_W-1:0]  sq_bell, cq_bell;
  logic [COUNT_W-1:0]  chunk;

  assign tail_inc  = (sq_tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : sq_tail_r + 1'b1;
  assign head_wrap = (cq_head_r == PTR_W'(QUEUE_DEPTH - 1));
  assign head_inc  = head_wrap ? '0 : cq_head_r + 1'b1;
  assign eff_ns    = (ns_r != '0) ? ns_r : NS_W'(1);
  // Queue 1: submission bell at twice the spacing, completion bell at three times.
  assign sq_bell   = DOORBELL_BASE + (DBOFF_W'(8) << stride_r);
  assign cq_bell   = sq_bell + (DBOFF_W'(4) << stride_r);
  assign chunk     = (left_r > CHUNK_MAX) ? CHUNK_MAX : left_r;

  always_comb begin
    res             = '0;
    res.namespace   = eff_ns;
    sq_tail_nxt     = sq_tail_r;
    cq_head_nxt     = cq_head_r;
    phase_nxt       = phase_r;
    cid_nxt         = cid_r;
    lba_nxt         = lba_r;
    left_nxt        = left_r;
    case (op_r)
      OP_COMPLETION: begin
        res.last = 1'b1;
        if (status_r[0] != phase_r) begin
          res.kind = KIND_NOT_READY;
        end else begin
          cq_head_nxt         = head_inc;
          phase_nxt           = head_wrap ? ~phase_r : phase_r;
          res.kind            = KIND_CONSUMED;
          res.doorbell_offset = cq_bell;
          res.doorbell_value  = SLOT_W'(head_inc);
          res.error           = |status_r[STATUS_W-1:1];
        end
      end
      OP_FLUSH: begin
        sq_tail_nxt         = tail_inc;
        cid_nxt             = cid_r + 1'b1;
        res.kind            = KIND_SUBMIT;
        res.opcode          = OPC_FLUSH;
        res.command_id      = cid_r;
        res.slot            = SLOT_W'(sq_tail_r);
        res.doorbell_offset = sq_bell;
        res.doorbell_value  = SLOT_W'(tail_inc);
        res.last            = 1'b1;
      end
      default: begin
        if (left_r == '0 || left_r > REQ_LIMIT) begin
          res.kind = KIND_REJECTED;
          res.last = 1'b1;
        end else begin
          sq_tail_nxt          = tail_inc;
          cid_nxt              = cid_r + 1'b1;
          left_nxt             = left_r - chunk;
          lba_nxt              = lba_r + LBA_W'(chunk);
          res.kind             = KIND_SUBMIT;
          res.opcode           = (op_r == OP_READ) ? OPC_READ : OPC_WRITE;
          res.command_id       = cid_r;
          res.start_block      = lba_r;
          res.blocks_minus_one = BM1_W'(chunk - 1'b1);
          res.slot             = SLOT_W'(sq_tail_r);
          res.doorbell_offset  = sq_bell;
          res.doorbell_value   = SLOT_W'(tail_inc);
          res.last             = (left_nxt == '0);
        end
      end
    endcase
  end

  assign sts.final_beat = res.last;
  assign out_data       = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r  <= '0;
      ns_r      <= '0;
      sq_tail_r <= '0;
      cq_head_r <= '0;
      phase_r   <= 1'b1;
      cid_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DOORBELL_STRIDE: stride_r <= cfg_wdata[STRIDE_W-1:0];
          CFG_NAMESPACE_ID:    ns_r     <= cfg_wdata[NS_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.emit) begin
        sq_tail_r <= sq_tail_nxt;
        cq_head_r <= cq_head_nxt;
        phase_r   <= phase_nxt;
        cid_r     <= cid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_data.op;
      lba_r    <= in_data.lba;
      left_r   <= in_data.count;
      status_r <= in_data.cpl_status;
    end else if (cmd.emit) begin
      lba_r  <= lba_nxt;
      left_r <= left_nxt;
    end
    if (cmd.emit) begin
      out_r <= res;
    end
  end

endmodule

@@ hw/rtl/nvme_io_queue_pair_host.sv @@
// Top level of the NVMe I/O queue pair host block.
//
// The in_ch channel takes one beat per request: a read or write (start block
// and sector count), a flush, or an observed completion entry. The out_ch
// channel gives the result beats of each request in order; the final beat of
// a request has last set. A read or write of n sectors yields ceil(n/8)
// command beats, each with its own command id, submission slot and doorbell
// write; a flush yields one command beat; a completion yields one beat,
// either consumed (head advance and completion doorbell) or not ready when
// the phase tag disagrees. A count of zero or above 512 gives one rejected beat.
// An accepted item is loaded into the working registers, and each result is
// built from them and registered in the output register. One result is
// produced per cycle while the receiver takes each beat. A new item is taken
// once the previous item's final result sits in the output register, even if
// that result has not yet been taken. Reset clears tail, head and command id,
// sets the expected phase to one and zeroes both configuration registers.
// When the receiver stalls, the output register holds its beat and the split
// pauses until the beat is taken. Config writes stride (index 0) and namespace
// (index 1); the user must make them only while idle, as the block itself
// does not enforce it.
module nvme_io_queue_pair_host import nvqp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  nvqp_in_if.sink               in_ch,
  nvqp_out_if.source            out_ch
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // The controller owns the handshakes and the output valid bit.
  nvqp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (dp_cmd),
    .sts       (dp_sts)
  );

  // The datapath holds queue state and builds each result beat.
  nvqp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_ch.data),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .out_data  (out_ch.data)
  );

endmodule

@@ hw/rtl/nvqp_checker.sv @@
// Port-level checker for the queue pair host and its bind.
`include "nvme_io_queue_pair_host_defines.svh"

module nvqp_checker import nvqp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `NVQP_ASSERT_IMP(a_side_fields_zero, out_valid && out_data.kind != KIND_SUBMIT, out_data.command_id == '0 && out_data.slot == '0 && out_data.opcode == '0, "command fields set on a non-command beat")

  `NVQP_ASSERT_IMP(a_single_beat_last, out_valid && (out_data.kind == KIND_NOT_READY || out_data.kind == KIND_REJECTED), out_data.last, "not-ready or rejected beat without last")

  `NVQP_ASSERT_IMP(a_no_accept_mid_request, out_valid && !out_data.last, !in_ready, "input ready while a request is still splitting")

  `NVQP_ASSERT_NXT(a_cid_sequence, out_valid && out_ready && out_data.kind == KIND_SUBMIT && !out_data.last, out_valid && out_data.kind == KIND_SUBMIT && out_data.command_id == $past(out_data.command_id) + 16'd1, "split commands not back to back with sequential ids")

  `NVQP_ASSERT_NXT(a_hold_stalled, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result beat changed")

endmodule

bind nvme_io_queue_pair_host nvqp_checker u_nvqp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
